@@ rtl/core/gpa_pkg.sv @@
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared types and constants for the GF(2) polynomial ALU: beat structs,
// operation codes, sequencer states and the control bundle to the shift unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpa_pkg;

   localparam int KIND_W = 3;
   localparam int OPND_W = 32;
   localparam int POLY_W = 63;
   localparam int DEG_W  = 6;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUO = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REM = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OPND_W-1:0] operand_a;
      logic [OPND_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [POLY_W-1:0] result_poly;
      logic [DEG_W-1:0]  poly_deg;
      logic              divide_by_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_BDEG,
      ST_INIT,
      ST_RUN,
      ST_FINISH,
      ST_RDEG,
      ST_DONE
   } state_type;

   // commands from the sequencer to the shift-and-xor unit
   typedef struct packed {
      logic load_direct;
      logic init;
      logic is_mul;
      logic step;
      logic take_quo;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/gf2_polynomial_alu.sv @@
// ----------------------------------------------------------------------------
// gf2_polynomial_alu
// Add, subtract, carry-less multiply, quotient and remainder on GF(2)
// polynomials, built around one shared shift-and-xor unit.
// ----------------------------------------------------------------------------
// latency is set by the state path from accept to result: add, subtract, zero
// divisor and unused codes pass DISPATCH, RDEG, DONE; multiply DISPATCH, RUN,
// FINISH, RDEG, DONE; divide DISPATCH, BDEG, INIT, RUN, FINISH, RDEG, DONE
// one beat in flight: busy is high through the strobe cycle, low in the cycle after
// RUN does one coefficient step per cycle and each degree lookup is registered
// strobe high for one cycle, cannot be held off; synchronous reset returns to idle
`default_nettype none

module gf2_polynomial_alu #(
   parameter int COEFF_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire gpa_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_strobe,
   output gpa_pkg::rsp_type      rsp_data
);

   localparam logic [gpa_pkg::OPND_W-1:0] OPND_MASK =
      gpa_pkg::OPND_W'((64'd1 << COEFF_BITS) - 64'd1);

   gpa_pkg::req_type              req_ff;
   gpa_pkg::ctl_type              ctl;
   logic [gpa_pkg::POLY_W-1:0]    direct;
   logic [gpa_pkg::POLY_W-1:0]    acc;
   logic [gpa_pkg::POLY_W-1:0]    deg_word;
   logic [gpa_pkg::DEG_W-1:0]     degree;
   logic                          last;
   logic                          deg_sel_b;
   logic                          div_zero;
   logic                          b_zero;

   // capture the beat with coefficients from COEFF_BITS up masked off
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff.kind      <= req_data.kind;
         req_ff.operand_a <= req_data.operand_a & OPND_MASK;
         req_ff.operand_b <= req_data.operand_b & OPND_MASK;
      end
   end

   assign b_zero = (req_ff.operand_b == '0);

   // results that need no iteration
   always_comb begin
      direct = '0;
      if (req_ff.kind == gpa_pkg::KIND_ADD || req_ff.kind == gpa_pkg::KIND_SUB) begin
         direct = gpa_pkg::POLY_W'(req_ff.operand_a ^ req_ff.operand_b);
      end else if (req_ff.kind == gpa_pkg::KIND_QUO) begin
         direct = gpa_pkg::POLY_W'(req_ff.operand_a);
      end
   end

   assign deg_word = deg_sel_b ? gpa_pkg::POLY_W'(req_ff.operand_b) : acc;

   gpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .kind      (req_ff.kind),
      .b_zero    (b_zero),
      .last      (last),
      .ctl       (ctl),
      .deg_sel_b (deg_sel_b),
      .busy      (busy),
      .done      (rsp_strobe),
      .div_zero  (div_zero)
   );

   gpa_shift_unit #(
      .COEFF_BITS (COEFF_BITS)
   ) u_shift (
      .clock      (clock),
      .ctl        (ctl),
      .opnd_a     (req_ff.operand_a),
      .opnd_b     (req_ff.operand_b),
      .direct     (direct),
      .div_degree (degree),
      .acc        (acc),
      .last       (last)
   );

   gpa_degree u_degree (
      .clock  (clock),
      .word   (deg_word),
      .degree (degree)
   );

   assign rsp_data.result_poly    = acc;
   assign rsp_data.poly_deg       = degree;
   assign rsp_data.divide_by_zero = div_zero;

endmodule

`default_nettype wire

@@ rtl/core/gpa_degree.sv @@
// ----------------------------------------------------------------------------
// gpa_degree
// Two-level degree finder: the first level registers a nonzero flag and the
// top set bit of each 8-bit group, the second picks the highest group.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_degree (
   input  wire logic                        clock,
   input  wire logic [gpa_pkg::POLY_W-1:0]  word,
   output logic      [gpa_pkg::DEG_W-1:0]   degree
);

   localparam int GRP_N = 8;
   localparam int GRP_W = 8;

   logic [GRP_N*GRP_W-1:0] padded;
   logic [GRP_N-1:0]       flag_in;
   logic [GRP_N-1:0]       flag_ff;
   logic [2:0]             idx_in [GRP_N];
   logic [2:0]             idx_ff [GRP_N];

   assign padded = (GRP_N*GRP_W)'(word);

   // per-group flag and top bit
   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         flag_in[g] = |padded[g*GRP_W +: GRP_W];
         idx_in[g]  = 3'd0;
         for (int i = 0; i < GRP_W; i++) begin
            if (padded[g*GRP_W + i]) begin
               idx_in[g] = 3'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      for (int g = 0; g < GRP_N; g++) begin
         idx_ff[g] <= idx_in[g];
      end
   end

   // highest nonzero group wins, zero word gives zero
   always_comb begin
      degree = '0;
      for (int g = 0; g < GRP_N; g++) begin
         if (flag_ff[g]) begin
            degree = {3'(g), idx_ff[g]};
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/gpa_shift_unit.sv @@
// ----------------------------------------------------------------------------
// gpa_shift_unit
// Shared shift-and-xor engine: one conditional xor per cycle while stepping
// serves both the carry-less multiply and the long division, MSB step first.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_shift_unit #(
   parameter int COEFF_BITS = 32
) (
   input  wire logic                        clock,
   input  wire gpa_pkg::ctl_type            ctl,
   input  wire logic [gpa_pkg::OPND_W-1:0]  opnd_a,
   input  wire logic [gpa_pkg::OPND_W-1:0]  opnd_b,
   input  wire logic [gpa_pkg::POLY_W-1:0]  direct,
   input  wire logic [gpa_pkg::DEG_W-1:0]   div_degree,
   output logic      [gpa_pkg::POLY_W-1:0]  acc,
   output logic                             last
);

   localparam int CNT_W = $clog2(COEFF_BITS);

   logic [gpa_pkg::POLY_W-1:0] acc_ff,  acc_in;
   logic [gpa_pkg::POLY_W-1:0] opnd_ff, opnd_in;
   logic [gpa_pkg::OPND_W-1:0] bsh_ff,  bsh_in;
   logic [gpa_pkg::OPND_W-1:0] quo_ff,  quo_in;
   logic [gpa_pkg::DEG_W-1:0]  top_ff,  top_in;
   logic [CNT_W-1:0]           cnt_ff,  cnt_in;
   logic                       mul_ff,  mul_in;
   logic                       hit;

   // multiply tests the next multiplier bit, divide the remainder's top bit
   assign hit = mul_ff ? bsh_ff[COEFF_BITS-1] : acc_ff[top_ff];

   always_comb begin
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      bsh_in  = bsh_ff;
      quo_in  = quo_ff;
      top_in  = top_ff;
      cnt_in  = cnt_ff;
      mul_in  = mul_ff;
      priority if (ctl.load_direct) begin
         acc_in = direct;
      end else if (ctl.init) begin
         mul_in  = ctl.is_mul;
         acc_in  = ctl.is_mul ? '0 : gpa_pkg::POLY_W'(opnd_a);
         opnd_in = gpa_pkg::POLY_W'(ctl.is_mul ? opnd_a : opnd_b) << (COEFF_BITS-1);
         bsh_in  = opnd_b;
         quo_in  = '0;
         top_in  = div_degree + gpa_pkg::DEG_W'(COEFF_BITS-1);
         cnt_in  = CNT_W'(COEFF_BITS-1);
      end else if (ctl.step) begin
         acc_in  = acc_ff ^ (hit ? opnd_ff : '0);
         opnd_in = opnd_ff >> 1;
         bsh_in  = bsh_ff << 1;
         quo_in  = {quo_ff[gpa_pkg::OPND_W-2:0], hit};
         top_in  = top_ff - gpa_pkg::DEG_W'(1);
         cnt_in  = cnt_ff - CNT_W'(1);
      end else if (ctl.take_quo) begin
         acc_in = gpa_pkg::POLY_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      bsh_ff  <= bsh_in;
      quo_ff  <= quo_in;
      top_ff  <= top_in;
      cnt_ff  <= cnt_in;
      mul_ff  <= mul_in;
   end

   assign acc  = acc_ff;
   assign last = (cnt_ff == '0);

endmodule

`default_nettype wire

@@ rtl/core/gpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpa_ctrl
// Sequencer: dispatches each beat to a direct result, a multiply or a
// division, steps the shift unit and runs the degree finder.
// ----------------------------------------------------------------------------
`default_nettype none

module gpa_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [gpa_pkg::KIND_W-1:0]  kind,
   input  wire logic                        b_zero,
   input  wire logic                        last,
   output gpa_pkg::ctl_type                 ctl,
   output logic                             deg_sel_b,
   output logic                             busy,
   output logic                             done,
   output logic                             div_zero
);

   gpa_pkg::state_type state_ff, state_in;
   logic               dz_ff, dz_in;
   logic               is_div;

   assign is_div = (kind == gpa_pkg::KIND_QUO) || (kind == gpa_pkg::KIND_REM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpa_pkg::ST_IDLE;
         dz_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dz_ff    <= dz_in;
      end
   end

   // next state and unit commands
   always_comb begin
      state_in  = state_ff;
      dz_in     = dz_ff;
      ctl       = '0;
      deg_sel_b = 1'b0;
      unique case (state_ff)
         gpa_pkg::ST_IDLE: begin
            if (start) begin
               state_in = gpa_pkg::ST_DISPATCH;
            end
         end
         gpa_pkg::ST_DISPATCH: begin
            dz_in = is_div && b_zero;
            if (kind == gpa_pkg::KIND_MUL) begin
               ctl.init   = 1'b1;
               ctl.is_mul = 1'b1;
               state_in   = gpa_pkg::ST_RUN;
            end else if (is_div && !b_zero) begin
               state_in = gpa_pkg::ST_BDEG;
            end else begin
               ctl.load_direct = 1'b1;
               state_in        = gpa_pkg::ST_RDEG;
            end
         end
         gpa_pkg::ST_BDEG: begin
            deg_sel_b = 1'b1;
            state_in  = gpa_pkg::ST_INIT;
         end
         gpa_pkg::ST_INIT: begin
            ctl.init = 1'b1;
            state_in = gpa_pkg::ST_RUN;
         end
         gpa_pkg::ST_RUN: begin
            ctl.step = 1'b1;
            if (last) begin
               state_in = gpa_pkg::ST_FINISH;
            end
         end
         gpa_pkg::ST_FINISH: begin
            ctl.take_quo = (kind == gpa_pkg::KIND_QUO);
            state_in     = gpa_pkg::ST_RDEG;
         end
         gpa_pkg::ST_RDEG: begin
            state_in = gpa_pkg::ST_DONE;
         end
         gpa_pkg::ST_DONE: begin
            state_in = gpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = gpa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy     = (state_ff != gpa_pkg::ST_IDLE);
   assign done     = (state_ff == gpa_pkg::ST_DONE);
   assign div_zero = dz_ff;

endmodule

`default_nettype wire

@@ verif/tb_gf2_polynomial_alu.sv @@
// ----------------------------------------------------------------------------
// tb_gf2_polynomial_alu
// Self-checking bench for the GF(2) polynomial ALU. A behavioral predictor
// computes every result as a beat is accepted. Each strobed result is then
// checked field by field against the oldest prediction. Directed corner
// beats come first, then three random phases with different sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gf2_polynomial_alu;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD   = 20;
   localparam int          COEFF_BITS   = 32;
   localparam logic [63:0] OPERAND_MASK = (64'd1 << COEFF_BITS) - 64'd1;
   localparam int          DRAIN_CYCLES = 60;
   localparam int          CYCLE_LIMIT  = 800000;
   localparam int          MAX_GAP      = 45;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   gpa_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   gpa_pkg::rsp_type rsp_data;

   gpa_pkg::rsp_type pending_results[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               kind_count[8];
   int               zero_divisor_count = 0;

   gf2_polynomial_alu #(
      .COEFF_BITS(COEFF_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // index of the highest set coefficient, zero polynomial gives 0
   function automatic int poly_degree(input logic [63:0] p);
      int d;
      d = 0;
      for (int i = 0; i < 64; i++) begin
         if (p[i]) d = i;
      end
      return d;
   endfunction

   // expected result for one operation beat
   function automatic gpa_pkg::rsp_type gf2_evaluate(input gpa_pkg::req_type op);
      logic [63:0]      a;
      logic [63:0]      b;
      logic [63:0]      acc;
      logic [63:0]      rem;
      logic [63:0]      quo;
      int               db;
      gpa_pkg::rsp_type res;
      a = {32'b0, op.operand_a} & OPERAND_MASK;
      b = {32'b0, op.operand_b} & OPERAND_MASK;
      acc = '0;
      res = '0;
      case (op.kind)
         gpa_pkg::KIND_ADD, gpa_pkg::KIND_SUB: begin
            acc = a ^ b;
         end
         gpa_pkg::KIND_MUL: begin
            for (int i = 0; i < COEFF_BITS; i++) begin
               if (b[i]) acc ^= a << i;
            end
         end
         gpa_pkg::KIND_QUO, gpa_pkg::KIND_REM: begin
            if (b == '0) begin
               res.divide_by_zero = 1'b1;
               acc = (op.kind == gpa_pkg::KIND_QUO) ? a : '0;
            end else begin
               // one shift-and-xor per quotient bit, top down
               db = poly_degree(b);
               rem = a;
               quo = '0;
               for (int s = COEFF_BITS - 1; s >= 0; s--) begin
                  if (s + db < 64 && rem[s + db]) begin
                     rem ^= b << s;
                     quo[s] = 1'b1;
                  end
               end
               acc = (op.kind == gpa_pkg::KIND_QUO) ? quo : rem;
            end
         end
         default: begin
            acc = '0;
         end
      endcase
      res.result_poly = acc[gpa_pkg::POLY_W-1:0];
      res.poly_deg = gpa_pkg::DEG_W'(poly_degree({1'b0, acc[gpa_pkg::POLY_W-1:0]}));
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch %s got %h want %h at cycle %0d",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // accepted beats feed the predictor, strobed results are checked
   always @(posedge clock) begin
      gpa_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_poly !== want.result_poly)
               report_mismatch("result_poly", 64'(rsp_data.result_poly),
                               64'(want.result_poly));
            if (rsp_data.poly_deg !== want.poly_deg)
               report_mismatch("poly_deg", 64'(rsp_data.poly_deg),
                               64'(want.poly_deg));
            if (rsp_data.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", 64'(rsp_data.divide_by_zero),
                               64'(want.divide_by_zero));
         end
      end
      if (!reset && start && busy === 1'b0) begin
         pending_results.push_back(gf2_evaluate(req_data));
         kind_count[req_data.kind]++;
         if (req_data.kind inside {gpa_pkg::KIND_QUO, gpa_pkg::KIND_REM} &&
             req_data.operand_b == '0)
            zero_divisor_count++;
      end
   end

   // hold one beat on the request port until it is taken
   task automatic issue_op(input logic [gpa_pkg::KIND_W-1:0] kind,
                           input logic [gpa_pkg::OPND_W-1:0] a,
                           input logic [gpa_pkg::OPND_W-1:0] b);
      gpa_pkg::req_type beat;
      beat.kind = kind;
      beat.operand_a = a;
      beat.operand_b = b;
      start <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // random sender gap, lands on any phase of the block's work
   task automatic sender_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   // operand with a spread of degrees and shapes
   function automatic logic [gpa_pkg::OPND_W-1:0] random_poly();
      case ($urandom_range(6))
         0:       return $urandom;
         1:       return $urandom >> $urandom_range(31);
         2:       return 32'd1 << $urandom_range(31);
         3:       return '0;
         4:       return '1;
         5:       return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_add_sub();
      issue_op(gpa_pkg::KIND_ADD, '1, '1);
      issue_op(gpa_pkg::KIND_ADD, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
      issue_op(gpa_pkg::KIND_SUB, '0, '1);
      issue_op(gpa_pkg::KIND_SUB, 32'h8000_0000, '0);
   endtask

   task automatic test_multiply();
      issue_op(gpa_pkg::KIND_MUL, '1, '1);
      issue_op(gpa_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000);
      issue_op(gpa_pkg::KIND_MUL, '0, '1);
      issue_op(gpa_pkg::KIND_MUL, 32'd1, 32'h1234_5678);
      issue_op(gpa_pkg::KIND_MUL, 32'd3, 32'd3);
   endtask

   task automatic test_divide();
      issue_op(gpa_pkg::KIND_QUO, '1, 32'd1);
      issue_op(gpa_pkg::KIND_REM, '1, 32'd1);
      issue_op(gpa_pkg::KIND_QUO, '1, 32'h8000_0000);
      issue_op(gpa_pkg::KIND_REM, 32'h8000_0001, 32'h8000_0000);
      // short dividend
      issue_op(gpa_pkg::KIND_QUO, 32'd3, 32'h100);
      issue_op(gpa_pkg::KIND_REM, 32'd3, 32'h100);
      issue_op(gpa_pkg::KIND_REM, 32'hDEAD_BEEF, 32'h0000_011B);
   endtask

   task automatic test_zero_divisor();
      issue_op(gpa_pkg::KIND_QUO, '1, '0);
      issue_op(gpa_pkg::KIND_REM, '1, '0);
      issue_op(gpa_pkg::KIND_QUO, '0, '0);
   endtask

   task automatic test_unused_kinds();
      for (int k = int'(gpa_pkg::KIND_REM) + 1; k < 2 ** gpa_pkg::KIND_W; k++)
         issue_op(gpa_pkg::KIND_W'(k), '1, '1);
   endtask

   task automatic test_random(input int count, input int gap_pct);
      logic [gpa_pkg::KIND_W-1:0] kind;
      logic [gpa_pkg::OPND_W-1:0] a;
      logic [gpa_pkg::OPND_W-1:0] b;
      int                         pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 10)      kind = gpa_pkg::KIND_ADD;
         else if (pick < 20) kind = gpa_pkg::KIND_SUB;
         else if (pick < 45) kind = gpa_pkg::KIND_MUL;
         else if (pick < 70) kind = gpa_pkg::KIND_QUO;
         else if (pick < 95) kind = gpa_pkg::KIND_REM;
         else kind = gpa_pkg::KIND_W'($urandom_range(2 ** gpa_pkg::KIND_W - 1, 5));
         a = random_poly();
         b = random_poly();
         // divisors mostly nonzero so the long division gets exercised
         if (kind inside {gpa_pkg::KIND_QUO, gpa_pkg::KIND_REM} && b == '0 &&
             $urandom_range(3) != 0)
            b = $urandom | 32'd1;
         sender_gap(gap_pct);
         issue_op(kind, a, b);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_add_sub();
      test_multiply();
      test_divide();
      test_zero_divisor();
      test_unused_kinds();
      test_random(480, 17);
      test_random(480, 74);
      test_random(490, 0);
      start <= 1'b0;

      // drain then let any late strobe show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: add %0d sub %0d mul %0d quo %0d rem %0d unused %0d beats",
               kind_count[gpa_pkg::KIND_ADD], kind_count[gpa_pkg::KIND_SUB],
               kind_count[gpa_pkg::KIND_MUL], kind_count[gpa_pkg::KIND_QUO],
               kind_count[gpa_pkg::KIND_REM],
               kind_count[5] + kind_count[6] + kind_count[7]);
      $display("summary: %0d zero divisors, %0d mismatches, %0d cycles",
               zero_divisor_count, mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
